// ===== hw/rtl/clx_pkg.sv =====
// Shared types, token codes and keyword spelling tables for the C-subset lexer.
package clx_pkg;

    // Token codes as seen on the result channel
    typedef enum logic [3:0] {
        KIND_INT    = 4'd0,
        KIND_RETURN = 4'd1,
        KIND_IDENT  = 4'd2,
        KIND_INTLIT = 4'd3,
        KIND_LBRACE = 4'd4,
        KIND_RBRACE = 4'd5,
        KIND_LPAREN = 4'd6,
        KIND_RPAREN = 4'd7,
        KIND_SEMI   = 4'd8
    } t_kind;

    // One result token queued for output
    typedef struct packed {
        t_kind kind;
        logic  last;
    } t_tok;

    // Tokens produced by one byte: count plus up to two entries
    typedef struct packed {
        logic [1:0] cnt;
        t_tok       tok0;
        t_tok       tok1;
    } t_push;

    localparam int QDEPTH = 4;
    localparam int QIDX_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [2:0] LEN_MAX    = 3'd7;
    localparam logic [2:0] LEN_INT    = 3'd3;
    localparam logic [2:0] LEN_RETURN = 3'd6;

    // Spelling of "int", indexed by character position
    function automatic logic [7:0] kw_int_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = 8'h69; // i
            2'd1:    ch = 8'h6E; // n
            2'd2:    ch = 8'h74; // t
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Spelling of "return", indexed by character position
    function automatic logic [7:0] kw_ret_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h72; // r
            3'd1:    ch = 8'h65; // e
            3'd2:    ch = 8'h74; // t
            3'd3:    ch = 8'h75; // u
            3'd4:    ch = 8'h72; // r
            3'd5:    ch = 8'h6E; // n
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== hw/rtl/clx_if.sv =====
// Valid/ready channel interfaces for source bytes and result tokens.
interface clx_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface clx_tok_if;
    logic       valid;
    logic       ready;
    logic [3:0] token_kind;
    logic       last_of_run;

    modport source (output valid, output token_kind, output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input last_of_run, output ready);
endinterface

// ===== hw/rtl/c_subset_token_lexer_core.sv =====
// Top level of the C-subset token lexer: input register, word tracker, result queue.
//
//  channel   dir  payload                         transfer when
//  i_byte    in   byte_in[7:0]                    valid && ready
//  o_tok     out  token_kind[3:0], last_of_run    valid && ready
//
//  One byte per cycle is taken while the queue has room; each byte is registered, classified
//  from that register once the queue has room, and its 0..2 tokens land in a 4-entry queue.
//  Token output runs at one per cycle while o_tok.ready is high, so bytes that yield pairs drain at half rate.
//  Reset (i_rst_n low, synchronous) empties the word and the queue.
//  A stall on o_tok backs up into the queue and then holds i_byte.ready low.
module c_subset_token_lexer_core
    import clx_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    clx_byte_if.sink  i_byte,
    clx_tok_if.source o_tok
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       room;
    logic       adv;
    t_push      push;
    t_push      push_gated;

    assign adv          = r_in_valid && room;
    assign i_byte.ready = !r_in_valid || room;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.valid && i_byte.ready) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.byte_in;
        end
    end

    clx_word u_word (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_byte  (r_in_byte),
        .o_push  (push)
    );

    // Only a byte that moves on may push tokens
    always_comb begin
        push_gated = push;
        if (!adv) begin
            push_gated.cnt = 2'd0;
        end
    end

    clx_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_gated),
        .o_room  (room),
        .o_tok   (o_tok)
    );

endmodule

// ===== hw/rtl/clx_word.sv =====
// Word tracker: keeps the running word flags and classifies it on a delimiter.
module clx_word
    import clx_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [7:0] i_byte,
    output t_push      o_push
);

    logic [2:0] r_len;
    logic       r_first_letter;
    logic       r_all_digits;
    logic       r_int_pfx;
    logic       r_ret_pfx;

    logic       is_upper, is_lower, is_letter, is_digit, is_alnum;
    logic       is_delim;
    logic       p_valid;
    t_kind      p_kind;
    logic       w_valid;
    t_kind      w_kind;
    logic       n_int_hit, n_ret_hit;

    // Character classes
    assign is_upper  = (i_byte >= 8'h41) && (i_byte <= 8'h5A);
    assign is_lower  = (i_byte >= 8'h61) && (i_byte <= 8'h7A);
    assign is_letter = is_upper || is_lower;
    assign is_digit  = (i_byte >= 8'h30) && (i_byte <= 8'h39);
    assign is_alnum  = is_letter || is_digit;

    // Delimiters and their punctuation tokens (space has none)
    always_comb begin
        p_valid  = 1'b1;
        p_kind   = KIND_SEMI;
        is_delim = 1'b1;
        case (i_byte)
            8'h7B:   p_kind = KIND_LBRACE;
            8'h7D:   p_kind = KIND_RBRACE;
            8'h28:   p_kind = KIND_LPAREN;
            8'h29:   p_kind = KIND_RPAREN;
            8'h3B:   p_kind = KIND_SEMI;
            8'h20:   p_valid = 1'b0;
            default: begin
                p_valid  = 1'b0;
                is_delim = 1'b0;
            end
        endcase
    end

    // Word classification, keywords first
    always_comb begin
        w_valid = 1'b1;
        w_kind  = KIND_IDENT;
        if (r_len == LEN_INT && r_int_pfx) begin
            w_kind = KIND_INT;
        end else if (r_len == LEN_RETURN && r_ret_pfx) begin
            w_kind = KIND_RETURN;
        end else if (r_len != 3'd0 && r_first_letter) begin
            w_kind = KIND_IDENT;
        end else if (r_len != 3'd0 && r_all_digits) begin
            w_kind = KIND_INTLIT;
        end else begin
            w_valid = 1'b0;
        end
    end

    // Pack word token ahead of punctuation, last flag on the final one
    always_comb begin
        o_push.cnt       = 2'd0;
        o_push.tok0.kind = w_valid ? w_kind : p_kind;
        o_push.tok0.last = ~(w_valid && p_valid);
        o_push.tok1.kind = p_kind;
        o_push.tok1.last = 1'b1;
        if (is_delim) begin
            o_push.cnt = {1'b0, w_valid} + {1'b0, p_valid};
        end
    end

    // Keyword prefix checks against the next expected character
    assign n_int_hit = (r_len < LEN_INT) && (i_byte == kw_int_char(r_len[1:0]));
    assign n_ret_hit = (r_len < LEN_RETURN) && (i_byte == kw_ret_char(r_len));

    // Word state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len          <= 3'd0;
            r_first_letter <= 1'b0;
            r_all_digits   <= 1'b1;
            r_int_pfx      <= 1'b1;
            r_ret_pfx      <= 1'b1;
        end else if (i_en) begin
            if (is_delim) begin
                r_len          <= 3'd0;
                r_first_letter <= 1'b0;
                r_all_digits   <= 1'b1;
                r_int_pfx      <= 1'b1;
                r_ret_pfx      <= 1'b1;
            end else if (is_alnum) begin
                if (r_len == 3'd0) begin
                    r_first_letter <= is_letter;
                end
                if (!is_digit) begin
                    r_all_digits <= 1'b0;
                end
                r_int_pfx <= r_int_pfx && n_int_hit;
                r_ret_pfx <= r_ret_pfx && n_ret_hit;
                if (r_len != LEN_MAX) begin
                    r_len <= r_len + 3'd1;
                end
            end
        end
    end

    // A delimiter always leaves an empty word behind
    a_clear_on_delim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && is_delim) |=> (r_len == 3'd0 && r_all_digits && r_int_pfx && r_ret_pfx))
        else $error("word state not cleared after delimiter");

    // The int prefix flag cannot survive past its keyword length
    a_int_pfx_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len > LEN_INT) |-> !r_int_pfx)
        else $error("int prefix flag set beyond keyword length");

    // Two tokens only when both word and punctuation exist, marked in order
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.cnt == 2'd2) |-> (!o_push.tok0.last && w_valid && p_valid))
        else $error("bad token pair");

endmodule

// ===== hw/rtl/clx_outq.sv =====
// Result queue: takes up to two tokens per cycle, hands out one per transfer.
module clx_outq
    import clx_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_push           i_push,
    output logic            o_room,
    clx_tok_if.source       o_tok
);

    t_tok              r_mem [QDEPTH];
    logic [QIDX_W-1:0] r_wr;
    logic [QIDX_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              pop;
    logic [QIDX_W-1:0] wr_next;

    assign pop     = o_tok.valid && o_tok.ready;
    assign wr_next = r_wr + QIDX_W'(1);

    // Room for a worst-case pair from the next byte
    assign o_room = r_cnt <= QCNT_W'(QDEPTH - 2);

    assign o_tok.valid       = r_cnt != '0;
    assign o_tok.token_kind  = r_mem[r_rd].kind;
    assign o_tok.last_of_run = r_mem[r_rd].last;

    // Storage writes, two slots when a pair arrives
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.tok0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_next] <= i_push.tok1;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + QIDX_W'(i_push.cnt);
            if (pop) begin
                r_rd <= r_rd + QIDX_W'(1);
            end
            r_cnt <= r_cnt + QCNT_W'(i_push.cnt) - QCNT_W'(pop);
        end
    end

    // Never overfill
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.cnt != 2'd0) |-> (r_cnt + QCNT_W'(i_push.cnt) <= QCNT_W'(QDEPTH)))
        else $error("result queue overflow");

    // A lone transfer shrinks the count by one
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_push.cnt == 2'd0) |=> (r_cnt == $past(r_cnt) - QCNT_W'(1)))
        else $error("count not decremented on transfer");

    // Write and read pointers stay apart by the fill count
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr == r_rd + r_cnt[QIDX_W-1:0])
        else $error("queue pointers disagree with count");

endmodule

// ===== verif/token_stream_checker.sv =====
// Token scoreboard for the C-subset lexer: predicts tokens from accepted bytes and checks them.
module token_stream_checker
    import clx_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    clx_byte_if  i_byte_mon,
    clx_tok_if   i_tok_mon,
    output int   o_fail_cnt,
    output int   o_pending,
    output int   o_tok_cnt
);

    localparam logic [7:0]  CH_SPACE   = 8'h20;
    localparam logic [7:0]  CH_LPAREN  = 8'h28;
    localparam logic [7:0]  CH_RPAREN  = 8'h29;
    localparam logic [7:0]  CH_SEMI    = 8'h3B;
    localparam logic [7:0]  CH_LBRACE  = 8'h7B;
    localparam logic [7:0]  CH_RBRACE  = 8'h7D;
    localparam logic [23:0] SPELL_INT  = "int";
    localparam logic [47:0] SPELL_RET  = "return";
    localparam int          MAX_PRINTS = 40;

    // Word tracker state, mirrored from the block's behavior
    logic [2:0] word_len;
    logic       starts_alpha;
    logic       only_digits;
    logic       int_ok;
    logic       ret_ok;

    t_tok tokens_due[$];
    t_tok want;
    int   fail_cnt = 0;
    int   tok_cnt = 0;

    assign o_fail_cnt = fail_cnt;
    assign o_tok_cnt  = tok_cnt;

    task automatic report_mismatch(input string msg);
        if (fail_cnt < MAX_PRINTS)
            $display("MISMATCH at %0t: %s", $time, msg);
        fail_cnt++;
    endtask

    function automatic void clear_word();
        word_len     = 3'd0;
        starts_alpha = 1'b0;
        only_digits  = 1'b1;
        int_ok       = 1'b1;
        ret_ok       = 1'b1;
    endfunction

    // Advance the word state by one byte and queue the tokens it yields
    function automatic void lex_byte(input logic [7:0] ch);
        logic  is_alpha;
        logic  is_num;
        logic  has_word;
        logic  has_punct;
        t_kind wk;
        t_kind pk;
        int    pos;
        t_tok  tk;

        is_alpha  = (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A);
        is_num    = (ch >= 8'h30 && ch <= 8'h39);
        has_punct = 1'b1;
        pk        = KIND_SEMI;
        case (ch)
            CH_LBRACE: pk = KIND_LBRACE;
            CH_RBRACE: pk = KIND_RBRACE;
            CH_LPAREN: pk = KIND_LPAREN;
            CH_RPAREN: pk = KIND_RPAREN;
            CH_SEMI:   pk = KIND_SEMI;
            default:   has_punct = 1'b0;
        endcase

        if (has_punct || ch == CH_SPACE) begin
            // delimiter: classify the finished word, then its own punctuation
            has_word = 1'b1;
            wk       = KIND_IDENT;
            if (word_len == 3'd3 && int_ok)
                wk = KIND_INT;
            else if (word_len == 3'd6 && ret_ok)
                wk = KIND_RETURN;
            else if (word_len != 3'd0 && starts_alpha)
                wk = KIND_IDENT;
            else if (word_len != 3'd0 && only_digits)
                wk = KIND_INTLIT;
            else
                has_word = 1'b0;
            if (has_word) begin
                tk.kind = wk;
                tk.last = !has_punct;
                tokens_due = {tokens_due, tk};
            end
            if (has_punct) begin
                tk.kind = pk;
                tk.last = 1'b1;
                tokens_due = {tokens_due, tk};
            end
            clear_word();
        end else if (is_alpha || is_num) begin
            pos = int'(word_len);
            if (pos == 0)
                starts_alpha = is_alpha;
            if (!is_num)
                only_digits = 1'b0;
            if (pos >= 3 || ch != SPELL_INT[8*(2-pos) +: 8])
                int_ok = 1'b0;
            if (pos >= 6 || ch != SPELL_RET[8*(5-pos) +: 8])
                ret_ok = 1'b0;
            if (word_len != 3'd7)
                word_len = word_len + 3'd1;
        end
        // anything else is dropped and leaves the word open
    endfunction

    // Sample both channels at each edge; input side first
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_word();
            tokens_due.delete();
        end else begin
            if (i_byte_mon.valid === 1'b1 && i_byte_mon.ready === 1'b1)
                lex_byte(i_byte_mon.byte_in);
            if (i_tok_mon.valid === 1'b1 && i_tok_mon.ready === 1'b1) begin
                tok_cnt++;
                if (tokens_due.size() == 0) begin
                    report_mismatch($sformatf("token kind %0d last %0b with none expected",
                                              i_tok_mon.token_kind, i_tok_mon.last_of_run));
                end else begin
                    want = tokens_due.pop_front();
                    if (i_tok_mon.token_kind !== want.kind)
                        report_mismatch($sformatf("token_kind %0d, expected %0d",
                                                  i_tok_mon.token_kind, want.kind));
                    if (i_tok_mon.last_of_run !== want.last)
                        report_mismatch($sformatf("last_of_run %0b, expected %0b (kind %0d)",
                                                  i_tok_mon.last_of_run, want.last,
                                                  want.kind));
                end
            end
        end
        o_pending <= tokens_due.size();
    end

endmodule

// ===== verif/testbench.sv =====
// Top of the lexer testbench: clock, reset, byte stimulus, token back-pressure and verdict.
module testbench;

    localparam int RANDOM_BYTES = 1450;
    localparam int SETTLE_CYC   = 16;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    logic i_clk;
    logic i_rst_n;
    int   fail_cnt;
    int   pending;
    int   tok_cnt;

    clx_byte_if byte_ch ();
    clx_tok_if  tok_ch ();

    c_subset_token_lexer_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_tok   (tok_ch)
    );

    token_stream_checker chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte_mon (byte_ch),
        .i_tok_mon  (tok_ch),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending),
        .o_tok_cnt  (tok_cnt)
    );

    // Source text waiting to be sent, plus run bookkeeping
    logic [7:0] src_buf[$];
    int         sent_cnt;
    int         directed_cnt;
    int         word_cnt;
    int         drain_cnt;
    int         junk_pct;
    int         calm_left;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #(8 * 800000);
        $display("simulation failed");
        $finish;
    end

    // Mostly short gaps, a few long ones, and stretches with none
    function automatic int pick_gap();
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm_left = $urandom_range(30, 120);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] rand_letter();
        logic [7:0] c;
        c = 8'h61 + 8'($urandom_range(0, 25));
        if ($urandom_range(0, 3) == 0)
            c = c ^ 8'h20;
        return c;
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'h30 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_alnum();
        if ($urandom_range(0, 2) == 0)
            return rand_digit();
        return rand_letter();
    endfunction

    // Bytes the lexer drops without ending the word
    function automatic logic [7:0] rand_junk();
        case ($urandom_range(0, 5))
            0:       return 8'h5F;
            1:       return 8'h0A;
            2:       return 8'h09;
            3:       return 8'h21;
            4:       return 8'h00;
            default: return 8'h80 | 8'($urandom_range(0, 127));
        endcase
    endfunction

    function automatic logic [7:0] rand_delim();
        case ($urandom_range(0, 7))
            0, 1:    return CH_SPACE;
            2:       return CH_LBRACE;
            3:       return CH_RBRACE;
            4:       return CH_LPAREN;
            5:       return CH_RPAREN;
            default: return CH_SEMI;
        endcase
    endfunction

    // Append one byte to the source text
    task automatic append_src(input logic [7:0] b);
        src_buf = {src_buf, b};
    endtask

    task automatic put_byte(input logic [7:0] b);
        if (junk_pct != 0 && $urandom_range(0, 99) < junk_pct)
            append_src(rand_junk());
        append_src(b);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    // One word of random shape followed by a delimiter
    task automatic make_word();
        int         sel;
        int         n;
        string      kw;
        logic [7:0] c;

        sel = $urandom_range(0, 99);
        if (sel < 14) begin
            put_text("int");
        end else if (sel < 28) begin
            put_text("return");
        end else if (sel < 40) begin
            // keyword prefix, extension or case variant
            if ($urandom_range(0, 1) == 0)
                kw = "int";
            else
                kw = "return";
            n = $urandom_range(1, kw.len());
            for (int i = 0; i < n; i++) begin
                c = kw[i];
                if ($urandom_range(0, 7) == 0)
                    c = c ^ 8'h20;
                put_byte(c);
            end
            if (n == kw.len() || $urandom_range(0, 1) == 1)
                repeat ($urandom_range(1, 2)) put_byte(rand_alnum());
        end else if (sel < 65) begin
            put_byte(rand_letter());
            repeat ($urandom_range(0, 9)) put_byte(rand_alnum());
        end else if (sel < 80) begin
            repeat ($urandom_range(1, 10)) put_byte(rand_digit());
        end else if (sel < 88) begin
            // digit first with a letter later
            put_byte(rand_digit());
            repeat ($urandom_range(0, 2)) put_byte(rand_digit());
            put_byte(rand_letter());
            repeat ($urandom_range(0, 2)) put_byte(rand_alnum());
        end else if (sel >= 94) begin
            // raw noise over the whole byte range
            repeat ($urandom_range(1, 6)) append_src(8'($urandom_range(0, 255)));
        end
        append_src(rand_delim());
    endtask

    // Offer one byte and hold it until the transfer
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.byte_in <= b;
        do @(posedge i_clk); while (byte_ch.ready !== 1'b1);
        sent_cnt++;
    endtask

    task automatic send_buf();
        foreach (src_buf[i])
            send_byte(src_buf[i]);
        src_buf.delete();
    endtask

    // Stop sending until every predicted token has come out
    task automatic drain_wait();
        byte_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        drain_cnt++;
    endtask

    // Result side back-pressure
    initial begin
        int   r;
        int   hold_left;
        logic ready_now;
        hold_left     = 0;
        ready_now     = 1'b0;
        tok_ch.ready  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0) begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    ready_now = 1'b1;
                    hold_left = $urandom_range(40, 150);
                end else if (r < 55) begin
                    ready_now = 1'b1;
                    hold_left = $urandom_range(1, 8);
                end else if (r < 85) begin
                    ready_now = 1'b0;
                    hold_left = $urandom_range(1, 3);
                end else if (r < 96) begin
                    ready_now = 1'b0;
                    hold_left = $urandom_range(4, 12);
                end else begin
                    ready_now = 1'b0;
                    hold_left = $urandom_range(20, 40);
                end
            end
            hold_left--;
            tok_ch.ready <= ready_now;
        end
    end

    // Stimulus and verdict
    initial begin
        byte_ch.valid   = 1'b0;
        byte_ch.byte_in = 8'h00;
        i_rst_n         = 1'b0;
        sent_cnt        = 0;
        word_cnt        = 0;
        drain_cnt       = 0;
        junk_pct        = 0;
        calm_left       = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: both keywords, literal with dropped bytes, lone punctuation,
        // a mixed word ended by space, a word long enough to saturate the length
        put_text("int{");
        put_text("return(");
        put_text("7");
        put_byte(8'hFF);
        put_text("_}");
        put_text(";");
        put_text("1a ");
        put_text("abcdefgh)");
        send_buf();
        directed_cnt = sent_cnt;

        // random text, mostly well-formed words
        junk_pct = 6;
        while (sent_cnt - directed_cnt < RANDOM_BYTES) begin
            make_word();
            send_buf();
            word_cnt++;
            if (word_cnt % 200 == 100)
                drain_wait();
        end

        drain_wait();
        repeat (SETTLE_CYC) @(posedge i_clk);

        $display("Covered %0d source bytes (%0d directed, %0d words) and %0d tokens checked,",
                 sent_cnt, directed_cnt, word_cnt, tok_cnt);
        $display("with %0d full drains under random stalls; %0d mismatches.",
                 drain_cnt, fail_cnt);
        if (fail_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== c_subset_token_lexer_core.f =====
hw/rtl/clx_pkg.sv
hw/rtl/clx_if.sv
hw/rtl/clx_word.sv
hw/rtl/clx_outq.sv
hw/rtl/c_subset_token_lexer_core.sv
verif/token_stream_checker.sv
verif/testbench.sv
